// File: src/tcw_pkg.sv
`default_nettype none
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  // field widths
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int ADDR_W = 11;
  localparam int CHAR_W = 8;
  localparam int CELL_W = 16;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [CHAR_W-1:0] DEFAULT_ATTR = 8'h07;
  localparam logic [CELL_W-1:0] BLANK_CELL   = {DEFAULT_ATTR, SPACE_CODE};

  typedef enum logic [1:0] {
    REQ_PUT   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_SWEEP = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

endpackage
`default_nettype wire

// File: src/text_console_writer.sv
`default_nettype none
// Channel | Dir | Ports                          | Payload
// in      | in  | in_tvalid, in_tready, in_tdata | req_type, char_code, cell_index
// out     | out | out_tvalid, out_tready, out_tdata | cursor, scrolled, cell_char/attr
//
// Put, read and unknown requests pass through accept, execute and hand-off.
// Clear and scroll walk the screen memory one cell per cycle through its single
// write port. Reset clears the cursor and control; the screen memory holds
// garbage until a clear. One item is in work at a time; a held result stalls
// the next item only at its hand-off.
module text_console_writer
  import tcw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // req_type[1:0], char_code[9:2], cell_index[20:10]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // cursor_row[4:0], cursor_col[11:5], scrolled[12],
                                       // cell_char[20:13], cell_attr[28:21]
);

  state_t state_r, state_nxt;

  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;   // row_r * COLUMNS

  logic [1:0]        req_r;
  logic [CHAR_W-1:0] char_r;
  logic              oob_r;

  logic              clr_mode_r, clr_mode_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;

  logic              res_scr_r, res_scr_nxt;
  logic [CHAR_W-1:0] res_char_r, res_char_nxt;
  logic [CHAR_W-1:0] res_attr_r, res_attr_nxt;

  logic              out_valid_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [COL_W-1:0]  out_col_r;
  logic              out_scr_r;
  logic [CHAR_W-1:0] out_char_r;
  logic [CHAR_W-1:0] out_attr_r;

  // screen memory
  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rdata_r;
  logic              re;
  logic [ADDR_W-1:0] raddr;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CELL_W-1:0] wdata;

  // sweep write stage, in the cycle after the read
  logic              wv_r;
  logic [ADDR_W-1:0] wa_r;
  logic              wblank_r;

  logic              in_acc;
  logic [1:0]        in_req;
  logic [ADDR_W-1:0] in_idx;
  logic              in_oob;
  logic [ADDR_W:0]   src_sum;
  logic [COL_W:0]    col_inc;
  logic              wrap;

  assign in_req  = in_tdata[1:0];
  assign in_idx  = in_tdata[20:10];
  assign in_oob  = ({1'b0, in_idx} >= (ADDR_W+1)'(CELLS));
  assign in_tready = (state_r == S_IDLE);
  assign in_acc  = in_tvalid && in_tready;
  assign src_sum = {1'b0, cnt_r} + (ADDR_W+1)'(COLUMNS);
  assign col_inc = {1'b0, col_r} + (COL_W+1)'(1);
  assign wrap    = (char_r == NEWLINE_CODE) || (col_inc == (COL_W+1)'(COLUMNS));

  // read port
  always_comb begin
    re    = 1'b0;
    raddr = src_sum[ADDR_W-1:0];
    if (state_r == S_IDLE) begin
      re    = in_acc && (in_req == REQ_READ) && !in_oob;
      raddr = in_idx;
    end else if (state_r == S_SWEEP) begin
      re    = !clr_mode_r && (src_sum < (ADDR_W+1)'(CELLS));
    end
  end

  // write port: sweep stage, else a put
  always_comb begin
    we    = 1'b0;
    waddr = wa_r;
    wdata = wblank_r ? BLANK_CELL : rdata_r;
    if (wv_r) begin
      we = 1'b1;
    end else if (state_r == S_EXEC && req_r == REQ_PUT && char_r != NEWLINE_CODE) begin
      we    = 1'b1;
      waddr = base_r + ADDR_W'(col_r);
      wdata = {DEFAULT_ATTR, char_r};
    end
  end

  // rows are copied upward, so a read never hits a cell already rewritten
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_comb begin
    state_nxt    = state_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    base_nxt     = base_r;
    clr_mode_nxt = clr_mode_r;
    cnt_nxt      = cnt_r;
    res_scr_nxt  = res_scr_r;
    res_char_nxt = res_char_r;
    res_attr_nxt = res_attr_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_scr_nxt  = 1'b0;
        res_char_nxt = '0;
        res_attr_nxt = '0;
        cnt_nxt      = '0;
        state_nxt    = S_DONE;
        case (req_r)
          REQ_PUT: begin
            if (wrap) begin
              col_nxt = '0;
              if (row_r == ROW_W'(ROWS - 1)) begin
                res_scr_nxt  = 1'b1;
                clr_mode_nxt = 1'b0;
                state_nxt    = S_SWEEP;
              end else begin
                row_nxt  = row_r + ROW_W'(1);
                base_nxt = base_r + ADDR_W'(COLUMNS);
              end
            end else begin
              col_nxt = col_inc[COL_W-1:0];
            end
          end
          REQ_CLEAR: begin
            row_nxt      = '0;
            col_nxt      = '0;
            base_nxt     = '0;
            clr_mode_nxt = 1'b1;
            state_nxt    = S_SWEEP;
          end
          REQ_READ: begin
            if (!oob_r) begin
              res_char_nxt = rdata_r[CHAR_W-1:0];
              res_attr_nxt = rdata_r[CELL_W-1:CHAR_W];
            end
          end
          default: begin
          end
        endcase
      end
      S_SWEEP: begin
        cnt_nxt = cnt_r + ADDR_W'(1);
        if (cnt_r == ADDR_W'(CELLS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_r       <= '0;
      col_r       <= '0;
      base_r      <= '0;
      wv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      base_r  <= base_nxt;
      wv_r    <= (state_r == S_SWEEP);
      if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    clr_mode_r <= clr_mode_nxt;
    cnt_r      <= cnt_nxt;
    res_scr_r  <= res_scr_nxt;
    res_char_r <= res_char_nxt;
    res_attr_r <= res_attr_nxt;
    wa_r       <= cnt_r;
    wblank_r   <= clr_mode_r || (src_sum >= (ADDR_W+1)'(CELLS));
    if (in_acc) begin
      req_r  <= in_req;
      char_r <= in_tdata[9:2];
      oob_r  <= in_oob;
    end
    if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
      out_row_r  <= row_r;
      out_col_r  <= col_r;
      out_scr_r  <= res_scr_r;
      out_char_r <= res_char_r;
      out_attr_r <= res_attr_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_attr_r, out_char_r, out_scr_r, out_col_r, out_row_r};

`ifndef ASSERT_OFF
  a_base_tracks_row: assert property (@(posedge clk) disable iff (!rst_n)
    base_r == ADDR_W'(row_r * COLUMNS))
    else $error("row base out of step with cursor row");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (row_r < ROW_W'(ROWS)) && ({1'b0, col_r} < (COL_W+1)'(COLUMNS)))
    else $error("cursor outside the screen");

  a_no_write_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !wv_r)
    else $error("sweep write still pending when a new item may enter");

  a_scroll_bottom_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_scr_r |-> out_row_r == ROW_W'(ROWS - 1))
    else $error("scrolled result not on the bottom row");
`endif

endmodule
`default_nettype wire
